### sv/stpd_pkg.sv
// stpd_pkg: shared types, constants and microcode table of the typed packet deframer
// used by stpd_useq, sof_typed_packet_deframer and stpd_chk; depends on nothing else
`default_nettype none

package stpd_pkg;

	// field and storage widths
	localparam int BYTE_W     = 8;
	localparam int IDX_W      = 10;
	localparam int LEN_W      = 11;
	localparam int KIND_W     = 3;
	localparam int HDR_DEPTH  = 8;
	localparam int HDR_IDX_W  = 3;
	localparam int FILL_W     = 4;
	localparam int STEP_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int TDATA_W    = 24;
	localparam int TUSER_W    = 4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_TYPE    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_LIMIT   = 2'd3;

	// configuration reset values
	localparam logic [BYTE_W-1:0] RST_START_FIRST  = 8'hAA;
	localparam logic [BYTE_W-1:0] RST_START_SECOND = 8'h55;
	localparam logic [BYTE_W-1:0] RST_NODE_TYPE    = 8'd16;
	localparam logic [BYTE_W-1:0] RST_NODE_LIMIT   = 8'd16;

	// packet kinds
	localparam logic [KIND_W-1:0] KIND_NODE     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_BED_SNAP = 3'd1;
	localparam logic [KIND_W-1:0] KIND_BED_STAT = 3'd2;
	localparam logic [KIND_W-1:0] KIND_HEALTH   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_SUMMARY  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_UNKNOWN  = 3'd5;

	// fixed type codes
	localparam logic [BYTE_W-1:0] TYPE_BED_SNAP = 8'h20;
	localparam logic [BYTE_W-1:0] TYPE_BED_STAT = 8'h22;
	localparam logic [BYTE_W-1:0] TYPE_HEALTH   = 8'h30;
	localparam logic [BYTE_W-1:0] TYPE_RECAP    = 8'h40;

	// nominal packet lengths and bed geometry
	localparam int BASE_LEN_NODE    = 42;
	localparam int BASE_LEN_BED     = 522;
	localparam int BASE_LEN_HEALTH  = 26;
	localparam int BASE_LEN_SUMMARY = 37;
	localparam logic [BYTE_W-1:0] BED_ROWS = 8'd32;
	localparam logic [BYTE_W-1:0] BED_COLS = 8'd16;

	// result kinds and error codes
	localparam logic RES_BYTE  = 1'b0;
	localparam logic RES_ERROR = 1'b1;
	localparam logic ERR_FIELD = 1'b0;
	localparam logic ERR_TYPE  = 1'b1;

	// microcode step addresses
	localparam logic [STEP_W-1:0] STEP_FETCH  = 3'd0;
	localparam logic [STEP_W-1:0] STEP_SCAN   = 3'd1;
	localparam logic [STEP_W-1:0] STEP_JUDGE  = 3'd2;
	localparam logic [STEP_W-1:0] STEP_EMIT   = 3'd3;
	localparam logic [STEP_W-1:0] STEP_RELOAD = 3'd4;
	localparam logic [STEP_W-1:0] STEP_NEXT   = 3'd5;

	typedef enum logic [2:0] {
		OP_FETCH  = 3'd0,
		OP_SCAN   = 3'd1,
		OP_JUDGE  = 3'd2,
		OP_EMIT   = 3'd3,
		OP_RELOAD = 3'd4,
		OP_NOP    = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		C_ALWAYS    = 3'd0,
		C_FULL      = 3'd1,
		C_OK        = 3'd2,
		C_EMIT_LAST = 3'd3,
		C_MORE      = 3'd4
	} cond_t;

	// one control word: operation, jump test, taken and not-taken targets
	typedef struct packed {
		op_t               op;
		cond_t             cond;
		logic [STEP_W-1:0] jmp;
		logic [STEP_W-1:0] nxt;
	} uword_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic stall;
		logic full;
		logic ok;
		logic emit_last;
		logic more;
	} useq_stat_t;

	// one result word
	typedef struct packed {
		logic              rkind;
		logic [KIND_W-1:0] pkind;
		logic [BYTE_W-1:0] value;
		logic [IDX_W-1:0]  index;
		logic              last;
		logic              err;
	} res_t;

	// control program
	function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
		uword_t w;
		case (step)
			STEP_FETCH:  w = '{op: OP_FETCH,  cond: C_ALWAYS,    jmp: STEP_SCAN,   nxt: STEP_SCAN};
			STEP_SCAN:   w = '{op: OP_SCAN,   cond: C_FULL,      jmp: STEP_JUDGE,  nxt: STEP_NEXT};
			STEP_JUDGE:  w = '{op: OP_JUDGE,  cond: C_OK,        jmp: STEP_EMIT,   nxt: STEP_RELOAD};
			STEP_EMIT:   w = '{op: OP_EMIT,   cond: C_EMIT_LAST, jmp: STEP_FETCH,  nxt: STEP_EMIT};
			STEP_RELOAD: w = '{op: OP_RELOAD, cond: C_ALWAYS,    jmp: STEP_SCAN,   nxt: STEP_SCAN};
			STEP_NEXT:   w = '{op: OP_NOP,    cond: C_MORE,      jmp: STEP_RELOAD, nxt: STEP_FETCH};
			default:     w = '{op: OP_NOP,    cond: C_ALWAYS,    jmp: STEP_FETCH,  nxt: STEP_FETCH};
		endcase
		return w;
	endfunction

	// packet length capped to the buffer and never below the header
	function automatic logic [LEN_W-1:0] pkt_len(input int base, input int max_bytes,
		input int hlen);
		int l;
		l = base;
		if (l > max_bytes) l = max_bytes;
		if (l < hlen) l = hlen;
		return LEN_W'(l);
	endfunction

endpackage

`default_nettype wire

### sv/stpd_useq.sv
// stpd_useq: step counter and control store of the deframer sequencer
// depends on stpd_pkg for the control word, status struct and program
`default_nettype none

module stpd_useq (
	input  wire                 clk,
	input  wire                 arst_n,
	input  stpd_pkg::useq_stat_t stat,
	output stpd_pkg::uword_t    uw
);
	import stpd_pkg::*;

	logic [STEP_W-1:0] pc_q;
	logic              take;

	// current control word
	assign uw = ucode_rom(pc_q);

	// jump condition select
	always_comb begin
		case (uw.cond)
			C_ALWAYS:    take = 1'b1;
			C_FULL:      take = stat.full;
			C_OK:        take = stat.ok;
			C_EMIT_LAST: take = stat.emit_last;
			C_MORE:      take = stat.more;
			default:     take = 1'b0;
		endcase
	end

	// step counter, held while the datapath stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_FETCH;
		end else if (!stat.stall) begin
			pc_q <= take ? uw.jmp : uw.nxt;
		end
	end

endmodule

`default_nettype wire

### sv/sof_typed_packet_deframer.sv
// sof_typed_packet_deframer: start-pattern hunt, typed header check and packet byte output
// depends on stpd_pkg and stpd_useq
//
//  channel   | dir | handshake              | contents
//  ----------+-----+------------------------+---------------------------------------------
//  s_        | in  | s_tvalid / s_tready    | tdata: rx_byte
//  m_        | out | m_tvalid / m_tready    | tdata: byte_value, byte_index, error_code
//            |     |                        | tuser: result_kind, packet_kind; tlast
//  cfg_      | in  | cfg_we (no wait)       | cfg_index, cfg_data
//
// a byte inside a packet or while hunting passes the fetch, scan and return steps
// a byte completing a good header passes fetch, scan and judge, then an emit for each header byte
// a failed header is rescanned from its second byte with reload, scan and return steps per byte
// emit and reload steps read through the one header-store read port the sequencer steps over
// the output register frees the input side; m_tready low stalls only emitting steps
// no clearing pass after reset: header entries are read only once written
`default_nettype none

module sof_typed_packet_deframer #(
	parameter int MAX_PACKET_BYTES = 522,
	parameter int HEADER_BYTES     = 8
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	input  wire  [stpd_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] rx_byte
	output logic                              m_tvalid,
	input  wire                               m_tready,
	output logic [stpd_pkg::TDATA_W-1:0]      m_tdata,   // [7:0] byte_value, [17:8] byte_index,
	                                                     // [18] error_code, [23:19] zero
	output logic [stpd_pkg::TUSER_W-1:0]      m_tuser,   // [0] result_kind, [3:1] packet_kind
	output logic                              m_tlast,
	input  wire                               cfg_we,
	input  wire  [stpd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [stpd_pkg::BYTE_W-1:0]       cfg_data
);
	import stpd_pkg::*;

	localparam int HDR_LEN = (HEADER_BYTES < 3) ? 3 : ((HEADER_BYTES > 8) ? 8 : HEADER_BYTES);
	localparam logic [LEN_W-1:0] LEN_NODE    = pkt_len(BASE_LEN_NODE, MAX_PACKET_BYTES, HDR_LEN);
	localparam logic [LEN_W-1:0] LEN_BED     = pkt_len(BASE_LEN_BED, MAX_PACKET_BYTES, HDR_LEN);
	localparam logic [LEN_W-1:0] LEN_HEALTH  = pkt_len(BASE_LEN_HEALTH, MAX_PACKET_BYTES, HDR_LEN);
	localparam logic [LEN_W-1:0] LEN_SUMMARY = pkt_len(BASE_LEN_SUMMARY, MAX_PACKET_BYTES,
		HDR_LEN);
	localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(HDR_LEN - 1);
	localparam logic [FILL_W-1:0] FILL_END  = FILL_W'(HDR_LEN);

	// configuration registers
	logic [BYTE_W-1:0] sf_q, ss_q, ntc_q, nlim_q;

	// header store and sequencer datapath
	logic [BYTE_W-1:0] hdr_q [HDR_DEPTH];
	logic [FILL_W-1:0] fill_q;
	logic              in_pkt_q;
	logic [KIND_W-1:0] kind_q;
	logic [IDX_W-1:0]  pos_q;
	logic [BYTE_W-1:0] cur_q;
	logic [FILL_W-1:0] rd_idx_q;
	logic              rescan_q;

	// output register
	logic              m_valid_q;
	res_t              res_q;

	uword_t            uw;
	useq_stat_t        stat;
	logic              out_free;
	logic [BYTE_W-1:0] hdr_rd;
	logic [KIND_W-1:0] jk;
	logic              judge_ok;
	logic [LEN_W-1:0]  cur_len;
	logic              pkt_last;
	logic              hdr_last;
	logic              emit_v;
	res_t              emit_w;
	logic              hdr_we;
	logic [HDR_IDX_W-1:0] hdr_wa;

	stpd_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.uw     (uw)
	);

	assign out_free = !m_valid_q || m_tready;
	assign hdr_rd   = hdr_q[rd_idx_q[HDR_IDX_W-1:0]];

	// type classification, node code takes precedence
	always_comb begin
		if (hdr_q[2] == ntc_q)              jk = KIND_NODE;
		else if (hdr_q[2] == TYPE_BED_SNAP) jk = KIND_BED_SNAP;
		else if (hdr_q[2] == TYPE_BED_STAT) jk = KIND_BED_STAT;
		else if (hdr_q[2] == TYPE_HEALTH)   jk = KIND_HEALTH;
		else if (hdr_q[2] == TYPE_RECAP)    jk = KIND_SUMMARY;
		else                                jk = KIND_UNKNOWN;
	end

	// header field checks, skipped where the byte is not held
	always_comb begin
		judge_ok = (jk != KIND_UNKNOWN);
		if (jk == KIND_NODE) begin
			if ((HDR_LEN > 4) && (hdr_q[4] >= nlim_q)) judge_ok = 1'b0;
		end else if ((jk == KIND_BED_SNAP) || (jk == KIND_BED_STAT)) begin
			if ((HDR_LEN > 6) && (hdr_q[6] != BED_ROWS)) judge_ok = 1'b0;
			if ((HDR_LEN > 7) && (hdr_q[7] != BED_COLS)) judge_ok = 1'b0;
		end
	end

	// length of the current packet kind
	always_comb begin
		case (kind_q)
			KIND_NODE:     cur_len = LEN_NODE;
			KIND_BED_SNAP: cur_len = LEN_BED;
			KIND_BED_STAT: cur_len = LEN_BED;
			KIND_HEALTH:   cur_len = LEN_HEALTH;
			default:       cur_len = LEN_SUMMARY;
		endcase
	end

	assign pkt_last = ({1'b0, pos_q} + LEN_W'(1)) >= cur_len;
	assign hdr_last = (LEN_W'(rd_idx_q) + LEN_W'(1)) >= cur_len;

	// stall and branch status for the sequencer
	always_comb begin
		case (uw.op)
			OP_FETCH: stat.stall = !s_tvalid;
			OP_SCAN:  stat.stall = in_pkt_q && !out_free;
			OP_JUDGE: stat.stall = !out_free;
			OP_EMIT:  stat.stall = !out_free;
			default:  stat.stall = 1'b0;
		endcase
		stat.full      = !in_pkt_q && (fill_q == FILL_LAST);
		stat.ok        = judge_ok;
		stat.emit_last = (rd_idx_q == FILL_LAST);
		stat.more      = rescan_q && (rd_idx_q != FILL_END);
	end

	assign s_tready = (uw.op == OP_FETCH);

	// result word produced by the current step
	always_comb begin
		emit_v = 1'b0;
		emit_w = '0;
		if (!stat.stall) begin
			case (uw.op)
				OP_SCAN: begin
					if (in_pkt_q) begin
						emit_v = 1'b1;
						emit_w = '{rkind: RES_BYTE, pkind: kind_q, value: cur_q, index: pos_q,
							last: pkt_last, err: ERR_FIELD};
					end
				end
				OP_JUDGE: begin
					if (!judge_ok) begin
						emit_v = 1'b1;
						emit_w = '{rkind: RES_ERROR,
							pkind: (jk == KIND_UNKNOWN) ? KIND_NODE : jk,
							value: hdr_q[2], index: '0, last: 1'b0,
							err: (jk == KIND_UNKNOWN) ? ERR_TYPE : ERR_FIELD};
					end
				end
				OP_EMIT: begin
					emit_v = 1'b1;
					emit_w = '{rkind: RES_BYTE, pkind: kind_q, value: hdr_rd,
						index: IDX_W'(rd_idx_q), last: hdr_last, err: ERR_FIELD};
				end
				default: begin
					emit_v = 1'b0;
				end
			endcase
		end
	end

	// header store write during hunting
	always_comb begin
		hdr_we = 1'b0;
		hdr_wa = '0;
		if ((uw.op == OP_SCAN) && !in_pkt_q) begin
			if (fill_q == '0) begin
				hdr_we = (cur_q == sf_q);
			end else if (fill_q == FILL_W'(1)) begin
				hdr_we = (cur_q == ss_q) || (cur_q == sf_q);
				hdr_wa = (cur_q == ss_q) ? HDR_IDX_W'(1) : '0;
			end else begin
				hdr_we = 1'b1;
				hdr_wa = fill_q[HDR_IDX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_we) hdr_q[hdr_wa] <= cur_q;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sf_q   <= RST_START_FIRST;
			ss_q   <= RST_START_SECOND;
			ntc_q  <= RST_NODE_TYPE;
			nlim_q <= RST_NODE_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_FIRST:  sf_q   <= cfg_data;
				CFG_START_SECOND: ss_q   <= cfg_data;
				CFG_NODE_TYPE:    ntc_q  <= cfg_data;
				CFG_NODE_LIMIT:   nlim_q <= cfg_data;
				default:          sf_q   <= sf_q;
			endcase
		end
	end

	// sequencer datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			in_pkt_q <= 1'b0;
			kind_q   <= KIND_NODE;
			pos_q    <= '0;
			cur_q    <= '0;
			rd_idx_q <= '0;
			rescan_q <= 1'b0;
		end else if (!stat.stall) begin
			case (uw.op)
				OP_FETCH: begin
					cur_q    <= s_tdata;
					rescan_q <= 1'b0;
				end
				OP_SCAN: begin
					if (in_pkt_q) begin
						pos_q <= pos_q + IDX_W'(1);
						if (pkt_last) begin
							in_pkt_q <= 1'b0;
							pos_q    <= '0;
							fill_q   <= '0;
						end
					end else if (fill_q == '0) begin
						if (cur_q == sf_q) fill_q <= FILL_W'(1);
					end else if (fill_q == FILL_W'(1)) begin
						if (cur_q == ss_q)      fill_q <= FILL_W'(2);
						else if (cur_q != sf_q) fill_q <= '0;
					end else begin
						fill_q <= fill_q + FILL_W'(1);
					end
				end
				OP_JUDGE: begin
					fill_q <= '0;
					if (judge_ok) begin
						kind_q   <= jk;
						rd_idx_q <= '0;
					end else begin
						rd_idx_q <= FILL_W'(1);
						rescan_q <= 1'b1;
					end
				end
				OP_EMIT: begin
					rd_idx_q <= rd_idx_q + FILL_W'(1);
					if (rd_idx_q == FILL_LAST) begin
						if (hdr_last) begin
							pos_q <= '0;
						end else begin
							in_pkt_q <= 1'b1;
							pos_q    <= IDX_W'(HDR_LEN);
						end
					end
				end
				OP_RELOAD: begin
					cur_q    <= hdr_rd;
					rd_idx_q <= rd_idx_q + FILL_W'(1);
				end
				default: begin
					rd_idx_q <= rd_idx_q;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit_v) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_v) res_q <= emit_w;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(TDATA_W - BYTE_W - IDX_W - 1)'(0), res_q.err, res_q.index, res_q.value};
	assign m_tuser  = {res_q.pkind, res_q.rkind};
	assign m_tlast  = res_q.last;

endmodule

`default_nettype wire

### sv/stpd_chk.sv
// stpd_chk: port-level checks on the deframer output words, bound to the top level
// depends on stpd_pkg for port widths and sof_typed_packet_deframer as the bind target
`default_nettype none

module stpd_chk (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              m_tvalid,
	input wire                              m_tready,
	input wire [stpd_pkg::TDATA_W-1:0]      m_tdata,
	input wire [stpd_pkg::TUSER_W-1:0]      m_tuser,
	input wire                              m_tlast
);
	import stpd_pkg::*;

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output word changed while stalled");

	// error events never close a packet
	a_err_nolast: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[0] == RES_ERROR) |-> !m_tlast)
		else $error("error event marked last");

	// error events carry index zero
	a_err_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[0] == RES_ERROR) |-> (m_tdata[17:8] == '0))
		else $error("error event with nonzero index");

	// packet bytes carry no error code
	a_byte_noerr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[0] == RES_BYTE) |-> (m_tdata[18] == ERR_FIELD))
		else $error("packet byte with error code");

endmodule

bind sof_typed_packet_deframer stpd_chk u_stpd_chk (.*);

`default_nettype wire
